// ----- design/clsr_pkg.sv -----
// Shared types and constants for the combined LCG shuffle generator.
// Used by clsr_mulmod and combined_lcg_shuffle_rng_top; no dependencies.
`timescale 1ns / 1ps

package clsr_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 32;
  localparam int unsigned VAL_W           = 31;

  // Both moduli sit just below 2^31, so a product folds as hi * (2^31 - m) + lo.
  localparam logic [30:0] MOD_ONE      = 31'd2147483563;
  localparam logic [30:0] MOD_TWO      = 31'd2147483399;
  localparam logic [15:0] MUL_ONE      = 16'd40014;
  localparam logic [15:0] MUL_TWO      = 16'd40692;
  localparam logic [7:0]  FOLD_ONE     = 8'd85;
  localparam logic [7:0]  FOLD_TWO     = 8'd249;
  localparam logic [30:0] SECOND_RESET = 31'd123456789;

  typedef enum logic {
    GEN_ONE = 1'b0,
    GEN_TWO = 1'b1
  } gen_sel_t;

  typedef struct packed {
    logic        valid;
    gen_sel_t    sel;
    logic [30:0] x;
  } mm_req_t;

  typedef struct packed {
    logic        valid;
    gen_sel_t    sel;
    logic [30:0] value;
  } mm_rsp_t;

  function automatic logic [15:0] mult_of(input gen_sel_t sel);
    return (sel == GEN_TWO) ? MUL_TWO : MUL_ONE;
  endfunction

  function automatic logic [7:0] fold_of(input gen_sel_t sel);
    return (sel == GEN_TWO) ? FOLD_TWO : FOLD_ONE;
  endfunction

  function automatic logic [30:0] mod_of(input gen_sel_t sel);
    return (sel == GEN_TWO) ? MOD_TWO : MOD_ONE;
  endfunction

endpackage

// ----- design/clsr_mulmod.sv -----
// Shared three-stage modular multiplier for both generators.
// Depends on clsr_pkg for the request/response structs and constants.
`timescale 1ns / 1ps

module clsr_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  clsr_pkg::mm_req_t req,
  output clsr_pkg::mm_rsp_t rsp
);

  logic                 v1_r;
  clsr_pkg::gen_sel_t   sel1_r;
  logic [46:0]          p_r;
  logic                 v2_r;
  clsr_pkg::gen_sel_t   sel2_r;
  logic [31:0]          f1_r;
  logic                 rsp_vld_r;
  clsr_pkg::gen_sel_t   rsp_sel_r;
  logic [30:0]          rsp_val_r;

  logic [31:0] f1_nxt;
  logic [31:0] f2;
  logic [31:0] mod_ext;
  logic [30:0] red_nxt;

  // fold the bits above 2^31 back in: 2^31 == fold (mod m)
  assign f1_nxt  = 32'(p_r[46:31]) * 32'(clsr_pkg::fold_of(sel1_r)) + 32'(p_r[30:0]);
  assign f2      = 32'(f1_r[30:0]) + (f1_r[31] ? 32'(clsr_pkg::fold_of(sel2_r)) : 32'd0);
  assign mod_ext = 32'(clsr_pkg::mod_of(sel2_r));
  assign red_nxt = (f2 >= mod_ext) ? 31'(f2 - mod_ext) : f2[30:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r      <= 1'b0;
      v2_r      <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      v1_r      <= req.valid;
      v2_r      <= v1_r;
      rsp_vld_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    sel1_r    <= req.sel;
    p_r       <= 47'(req.x) * 47'(clsr_pkg::mult_of(req.sel));
    sel2_r    <= sel1_r;
    f1_r      <= f1_nxt;
    rsp_sel_r <= sel2_r;
    rsp_val_r <= red_nxt;
  end

  assign rsp = '{valid: rsp_vld_r, sel: rsp_sel_r, value: rsp_val_r};

endmodule

// ----- design/combined_lcg_shuffle_rng_top.sv -----
// Top level of the combined LCG generator with shuffle table.
// Depends on clsr_pkg and clsr_mulmod; holds the table memory and sequencer.
`timescale 1ns / 1ps

// One item at a time. A draw is one table read plus the two generator
// steps through the shared three-stage modular multiplier, and its result
// is registered. A reseed first runs warm-up generator steps and then the
// steps that fill the table, back to back through that multiplier, each
// depending on the last, and then performs a draw. A finished result waits
// in the output register while the next item is taken; the block stalls
// only when it would overwrite an unread result. Results are integers in
// 1 .. 2147483562.
module combined_lcg_shuffle_rng_top #(
  parameter int unsigned TABLE_DEPTH = clsr_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] seed_value, [31] zero
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [30:0] random_value, [31] zero
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);
  localparam int unsigned QW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VW = 31 + QW;
  localparam logic [30:0] MOD_ONE_M1 = clsr_pkg::MOD_ONE - 31'd1;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_SEED      = 6'b000010,
    ST_SLOT      = 6'b000100,
    ST_DRAW_RD   = 6'b001000,
    ST_DRAW_WAIT = 6'b010000,
    ST_DONE      = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  logic [30:0]       first_r, first_nxt;
  logic [30:0]       second_r, second_nxt;
  logic [30:0]       last_output_r, last_output_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [AW-1:0]     slot_r, slot_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [30:0]       out_data_r, out_data_nxt;

  // shuffle table: one write port, one registered read port
  logic [30:0]       mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] vld_r;
  logic [30:0]       rd_data_r;
  logic              rd_vld_r;
  logic              mem_re;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [30:0]       mem_wd;

  clsr_pkg::mm_req_t mm_req;
  clsr_pkg::mm_rsp_t mm_rsp;

  logic              in_fire;
  logic [30:0]       seed_val;
  logic [VW-1:0]     scaled;
  logic [QW-1:0]     q0;
  logic [31:0]       rem;
  logic [QW:0]       q_full;
  logic [AW-1:0]     slot_calc;
  logic [30:0]       tbl_val;
  logic [30:0]       draw_res;
  logic              out_free;

  clsr_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign seed_val   = (in_tdata[30:0] == 31'd0) ? 31'd1 : in_tdata[30:0];
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  // slot = floor(last * depth / MOD_ONE); the true quotient is q0 or q0 + 1
  assign scaled    = VW'(last_output_r) * VW'(TABLE_DEPTH);
  assign q0        = scaled[VW-1:31];
  assign rem       = 32'(scaled[30:0]) + 32'(q0) * 32'(clsr_pkg::FOLD_ONE);
  assign q_full    = {1'b0, q0} + (QW + 1)'(rem >= 32'(clsr_pkg::MOD_ONE));
  assign slot_calc = (q_full >= (QW + 1)'(TABLE_DEPTH)) ? AW'(TABLE_DEPTH - 1)
                                                         : q_full[AW-1:0];

  // entries not yet written read as zero
  assign tbl_val  = rd_vld_r ? rd_data_r : 31'd0;
  assign draw_res = (tbl_val > second_r) ? (tbl_val - second_r)
                                         : (tbl_val + MOD_ONE_M1 - second_r);

  always_comb begin
    state_nxt       = state_r;
    first_nxt       = first_r;
    second_nxt      = second_r;
    last_output_nxt = last_output_r;
    cnt_nxt         = cnt_r;
    slot_nxt        = slot_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    mm_req.valid    = 1'b0;
    mm_req.sel      = clsr_pkg::GEN_ONE;
    mm_req.x        = first_r;
    mem_re          = 1'b0;
    mem_we          = 1'b0;
    mem_wa          = slot_r;
    mem_wd          = first_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            first_nxt    = seed_val;
            second_nxt   = seed_val;
            cnt_nxt      = CW'(TABLE_DEPTH + 7);
            mm_req.valid = 1'b1;
            mm_req.x     = seed_val;
            state_nxt    = ST_SEED;
          end else begin
            state_nxt = ST_SLOT;
          end
        end
      end
      ST_SEED: begin
        if (mm_rsp.valid) begin
          first_nxt = mm_rsp.value;
          if (cnt_r < CW'(TABLE_DEPTH)) begin
            mem_we = 1'b1;
            mem_wa = cnt_r[AW-1:0];
            mem_wd = mm_rsp.value;
          end
          if (cnt_r == '0) begin
            last_output_nxt = mm_rsp.value;
            state_nxt       = ST_SLOT;
          end else begin
            cnt_nxt      = cnt_r - CW'(1);
            mm_req.valid = 1'b1;
            mm_req.x     = mm_rsp.value;
          end
        end
      end
      ST_SLOT: begin
        slot_nxt     = slot_calc;
        mm_req.valid = 1'b1;
        mm_req.x     = first_r;
        state_nxt    = ST_DRAW_RD;
      end
      ST_DRAW_RD: begin
        mem_re       = 1'b1;
        mm_req.valid = 1'b1;
        mm_req.sel   = clsr_pkg::GEN_TWO;
        mm_req.x     = second_r;
        state_nxt    = ST_DRAW_WAIT;
      end
      ST_DRAW_WAIT: begin
        if (mm_rsp.valid) begin
          if (mm_rsp.sel == clsr_pkg::GEN_TWO) begin
            second_nxt = mm_rsp.value;
            state_nxt  = ST_DONE;
          end else begin
            first_nxt = mm_rsp.value;
          end
        end
      end
      ST_DONE: begin
        // hold until the previous result has been taken
        if (out_free) begin
          mem_we          = 1'b1;
          mem_wa          = slot_r;
          mem_wd          = first_r;
          last_output_nxt = draw_res;
          out_data_nxt    = draw_res;
          out_valid_nxt   = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      first_r       <= 31'd1;
      second_r      <= clsr_pkg::SECOND_RESET;
      last_output_r <= 31'd0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
      vld_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      first_r       <= first_nxt;
      second_r      <= second_nxt;
      last_output_r <= last_output_nxt;
      cnt_r         <= cnt_nxt;
      out_valid_r   <= out_valid_nxt;
      if (mem_we) begin
        vld_r[mem_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[slot_r];
      rd_vld_r  <= vld_r[slot_r];
    end
  end

  // multiplier results only show up while the sequencer waits for them
  a_rsp_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.valid |-> (state_r == ST_SEED || state_r == ST_DRAW_WAIT))
    else $error("multiplier result arrived in an unexpected state");

  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_output_r < clsr_pkg::MOD_ONE)
    else $error("last output not below first modulus");

  a_gen_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAW_WAIT && mm_rsp.valid && mm_rsp.sel == clsr_pkg::GEN_TWO)
      |-> $past(mm_rsp.valid && mm_rsp.sel == clsr_pkg::GEN_ONE))
    else $error("second generator result without first one just before");

  a_draw_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_tuser) |=> (state_r == ST_SLOT))
    else $error("draw transaction did not start slot selection");

endmodule
